// ===== sv/stqt_pkg.sv =====
// shared types and codes for the sorted expiry timer queue
package stqt_pkg;

    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [31:0] address;
        logic [63:0] delay;
        logic [63:0] expiry;
    } t_slot;

    typedef struct packed {
        logic  push;
        logic  pop;
        t_slot fresh;
    } t_ctl;

endpackage

// ===== sv/sorted_expiry_timer_queue.sv =====
// top level of the sorted expiry timer queue
//
// input channel: i_valid / o_stall with i_opcode, i_jump_address, i_wait_time, i_time_now
// output channel: o_valid / i_stall with o_status, o_head_address, o_head_wait,
//   o_head_expiry, o_entry_count, o_queue_empty
// every item gives exactly one result, registered when the item is taken
// throughput is one item per cycle while o_stall is low: the row of DEPTH cells compares
// all expiries against the new expiry in parallel and shifts right by one on insert,
// left on pop; the cell at the left end always holds the earliest entry
// push on a full queue reports full, pop or peek on an empty queue reports empty
// with zero head fields; opcode 3 does nothing and reports the count
// when the receiver stalls a pending result, o_stall rises and no item is taken
// until that result leaves
// reset empties the queue at once; entry payloads hold anything until written
module sorted_expiry_timer_queue import stqt_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_jump_address,
    input  logic [63:0] i_wait_time,
    input  logic [63:0] i_time_now,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_head_address,
    output logic [63:0] o_head_wait,
    output logic [63:0] o_head_expiry,
    output logic [4:0]  o_entry_count,
    output logic        o_queue_empty
);

    localparam int CW = $clog2(DEPTH + 1);

    t_slot             w_slot  [DEPTH];
    logic  [DEPTH-1:0] w_valid;
    logic  [DEPTH-1:0] w_keep;
    t_ctl              w_ctl;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic [1:0]    n_status;
    t_slot         n_head;
    t_slot         r_head;
    logic [1:0]    r_status;
    logic [CW-1:0] r_out_count;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_ctl.fresh.address = i_jump_address;
        w_ctl.fresh.delay   = i_wait_time;
        w_ctl.fresh.expiry  = i_time_now + i_wait_time;
        w_ctl.push = 1'b0;
        w_ctl.pop  = 1'b0;
        n_status   = ST_OK;
        n_head     = '0;
        n_count    = r_count;
        unique case (i_opcode)
            OP_PUSH: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.push = w_accept;
                    n_count    = r_count + CW'(1);
                end
            end
            OP_POP, OP_PEEK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head = w_slot[0];
                    if (i_opcode == OP_POP) begin
                        w_ctl.pop = w_accept;
                        n_count   = r_count - CW'(1);
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_slot w_prev_slot;
        logic  w_prev_valid;
        logic  w_prev_keep;
        t_slot w_next_slot;
        logic  w_next_valid;

        if (g == 0) begin : g_first
            assign w_prev_slot  = '0;
            assign w_prev_valid = 1'b0;
            assign w_prev_keep  = 1'b1;
        end else begin : g_mid
            assign w_prev_slot  = w_slot[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_keep  = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_slot  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_slot  = w_slot[g+1];
            assign w_next_valid = w_valid[g+1];
        end

        stqt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_slot  (w_prev_slot),
            .i_prev_valid (w_prev_valid),
            .i_prev_keep  (w_prev_keep),
            .i_next_slot  (w_next_slot),
            .i_next_valid (w_next_valid),
            .o_slot       (w_slot[g]),
            .o_valid      (w_valid[g]),
            .o_keep       (w_keep[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_head      <= n_head;
            r_out_count <= n_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_head_address = r_head.address;
    assign o_head_wait    = r_head.delay;
    assign o_head_expiry  = r_head.expiry;
    assign o_entry_count  = 5'(r_out_count);
    assign o_queue_empty  = (r_out_count == '0);

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == 32'($countones(w_valid)))
        else $error("entry count differs from occupied cells");

    a_cells_packed_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + DEPTH'(1)) & w_valid) == '0)
        else $error("occupied cells are not packed at the head");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.pop |=> r_count == $past(r_count) - CW'(1))
        else $error("pop did not remove one entry");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[0] && w_valid[1]) |-> w_slot[0].expiry <= w_slot[1].expiry)
        else $error("head entry is not the earliest");

endmodule

// ===== sv/stqt_cell.sv =====
// one cell of the sorted chain: holds one entry, shifts right on insert, left on pop
module stqt_cell import stqt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctl  i_ctl,
    input  t_slot i_prev_slot,
    input  logic  i_prev_valid,
    input  logic  i_prev_keep,
    input  t_slot i_next_slot,
    input  logic  i_next_valid,
    output t_slot o_slot,
    output logic  o_valid,
    output logic  o_keep
);

    t_slot r_slot;
    logic  r_valid;

    assign o_keep  = r_valid && (r_slot.expiry <= i_ctl.fresh.expiry);
    assign o_slot  = r_slot;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.push) begin
            if (!o_keep) begin
                r_valid <= i_prev_keep ? 1'b1 : i_prev_valid;
            end
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            if (!o_keep) begin
                r_slot <= i_prev_keep ? i_ctl.fresh : i_prev_slot;
            end
        end else if (i_ctl.pop) begin
            r_slot <= i_next_slot;
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// testbench for the sorted expiry timer queue: directed table, then random traffic vs a predictor
module testbench import stqt_pkg::*;;

    localparam logic [1:0]  OP_NONE      = 2'd3;
    localparam logic [63:0] MAX64        = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOP_BIT      = 64'h8000_0000_0000_0000;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
        logic [63:0] delay;
        logic [63:0] expiry;
        logic [4:0]  count;
        logic        empty_flag;
    } t_result;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] address;
        logic [63:0] delay;
        logic [63:0] time_now;
        logic [4:0]  reps;
        logic        typed;
        t_result     want;
    } t_row;

    localparam t_result NO_RESULT = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = OP_NONE;
    logic [31:0] i_jump_address = '0;
    logic [63:0] i_wait_time = '0;
    logic [63:0] i_time_now = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_head_address;
    logic [63:0] o_head_wait;
    logic [63:0] o_head_expiry;
    logic [4:0]  o_entry_count;
    logic        o_queue_empty;

    logic    pin_typed = 1'b0;
    t_result pin_want = '0;
    logic    no_idle = 1'b0;
    int      stall_left = 0;
    int      fail_count = 0;
    int      cycle_count = 0;

    t_slot   timer_list[$];
    t_result pending_results[$];

    // op, address, wait, now, repeats, typed, expected result
    t_row directed_rows [15] = '{
        '{OP_POP,  32'h0, 64'h0, 64'h0, 5'd1, 1'b1, '{ST_EMPTY, 32'h0, 64'h0, 64'h0, 5'd0, 1'b1}},
        '{OP_PEEK, 32'hFFFF_FFFF, MAX64, MAX64, 5'd1, 1'b1,
            '{ST_EMPTY, 32'h0, 64'h0, 64'h0, 5'd0, 1'b1}},
        '{OP_NONE, 32'h0, 64'h0, 64'h0, 5'd1, 1'b1, '{ST_OK, 32'h0, 64'h0, 64'h0, 5'd0, 1'b1}},
        '{OP_PUSH, 32'hFFFF_FFFF, MAX64, MAX64, 5'd1, 1'b1,
            '{ST_OK, 32'h0, 64'h0, 64'h0, 5'd1, 1'b0}},
        '{OP_PEEK, 32'h0, 64'h0, 64'h0, 5'd1, 1'b1,
            '{ST_OK, 32'hFFFF_FFFF, MAX64, 64'hFFFF_FFFF_FFFF_FFFE, 5'd1, 1'b0}},
        '{OP_PUSH, 32'h0, 64'h0, 64'h0, 5'd1, 1'b1, '{ST_OK, 32'h0, 64'h0, 64'h0, 5'd2, 1'b0}},
        '{OP_PEEK, 32'h0, 64'h0, 64'h0, 5'd1, 1'b1, '{ST_OK, 32'h0, 64'h0, 64'h0, 5'd2, 1'b0}},
        '{OP_PUSH, 32'h1234_5678, 64'd40, 64'd60, 5'd1, 1'b0, NO_RESULT},
        '{OP_PUSH, 32'h9ABC_DEF0, 64'd100, 64'd0, 5'd1, 1'b0, NO_RESULT},
        '{OP_PUSH, 32'h8000_0000, TOP_BIT, 64'd0, 5'd1, 1'b0, NO_RESULT},
        '{OP_PUSH, 32'h0000_1000, 64'd95, 64'd5, 5'd11, 1'b0, NO_RESULT},
        '{OP_PUSH, 32'h5A5A_5A5A, 64'd1, 64'd1, 5'd1, 1'b1,
            '{ST_FULL, 32'h0, 64'h0, 64'h0, 5'd16, 1'b0}},
        '{OP_POP,  32'h0, 64'h0, 64'h0, 5'd1, 1'b1, '{ST_OK, 32'h0, 64'h0, 64'h0, 5'd15, 1'b0}},
        '{OP_PEEK, 32'h0, 64'h0, 64'h0, 5'd1, 1'b0, NO_RESULT},
        '{OP_POP,  32'h0, 64'h0, 64'h0, 5'd1, 1'b0, NO_RESULT}
    };

    sorted_expiry_timer_queue DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result apply_timer_op(input logic [1:0] op, input logic [31:0] address,
                                               input logic [63:0] delay,
                                               input logic [63:0] time_now);
        t_result r;
        t_slot   entry;
        int      pos;
        r = '0;
        case (op)
            OP_PUSH: begin
                if (timer_list.size() >= DEPTH_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    entry.address = address;
                    entry.delay   = delay;
                    entry.expiry  = time_now + delay;
                    pos = timer_list.size();
                    // equal expiry goes behind the older entries
                    while (pos > 0 && timer_list[pos - 1].expiry > entry.expiry) pos--;
                    timer_list.insert(pos, entry);
                end
            end
            OP_POP, OP_PEEK: begin
                if (timer_list.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.address = timer_list[0].address;
                    r.delay   = timer_list[0].delay;
                    r.expiry  = timer_list[0].expiry;
                    if (op == OP_POP) void'(timer_list.pop_front());
                end
            end
            default: ;
        endcase
        r.count      = 5'(timer_list.size());
        r.empty_flag = (timer_list.size() == 0);
        return r;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] corner_value();
        case ($urandom_range(0, 3))
            0: return 64'h0;
            1: return MAX64;
            2: return TOP_BIT;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_result(input t_result want, input t_result got);
        check_field("status", 64'(want.status), 64'(got.status));
        check_field("head_address", 64'(want.address), 64'(got.address));
        check_field("head_wait", want.delay, got.delay);
        check_field("head_expiry", want.expiry, got.expiry);
        check_field("entry_count", 64'(want.count), 64'(got.count));
        check_field("queue_empty", 64'(want.empty_flag), 64'(got.empty_flag));
    endtask

    task automatic send_item(input logic [1:0] op, input logic [31:0] address,
                             input logic [63:0] delay, input logic [63:0] time_now,
                             input logic typed, input t_result want);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_opcode       <= op;
        i_jump_address <= address;
        i_wait_time    <= delay;
        i_time_now     <= time_now;
        pin_typed      <= typed;
        pin_want       <= want;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_result predicted;
        t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                predicted = apply_timer_op(i_opcode, i_jump_address, i_wait_time, i_time_now);
                pending_results.push_back(pin_typed ? pin_want : predicted);
            end
            if (o_valid && !i_stall) begin
                got = '{o_status, o_head_address, o_head_wait, o_head_expiry,
                        o_entry_count, o_queue_empty};
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none expected, actual status %0h count %0d",
                             $time, o_status, o_entry_count);
                    fail_count++;
                end else begin
                    compare_result(pending_results.pop_front(), got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (no_idle) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = idle_length() - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin
        int          push_pct;
        int          kind;
        logic [63:0] cluster_base;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [63:0] wt;
        logic [63:0] tn;
        push_pct = 50;
        cluster_base = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_item(directed_rows[r].op, directed_rows[r].address + 32'(k),
                          directed_rows[r].delay,
                          directed_rows[r].time_now + 64'((k % 3) * 5),
                          directed_rows[r].typed, directed_rows[r].want);
            end
        end
        hold_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 32 == 0) begin
                // alternate filling, draining and mixed phases
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
                no_idle <= ($urandom_range(0, 3) == 0);
                cluster_base = {$urandom, $urandom};
            end
            if (n == RANDOM_ITEMS / 2) hold_until_drained();
            if ($urandom_range(0, 99) < 4) op = OP_NONE;
            else if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
            else if ($urandom_range(0, 3) == 0) op = OP_PEEK;
            else op = OP_POP;
            addr = $urandom;
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                wt = {$urandom, $urandom};
                tn = {$urandom, $urandom};
            end else if (kind <= 7) begin
                // close expiries, many of them equal
                tn = cluster_base + 64'($urandom_range(0, 3));
                wt = 64'($urandom_range(0, 3));
            end else if (kind == 8) begin
                wt = corner_value();
                tn = corner_value();
            end else begin
                tn = {$urandom, $urandom};
                wt = 64'($urandom_range(0, 1000));
            end
            send_item(op, addr, wt, tn, 1'b0, NO_RESULT);
        end

        hold_until_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
